/* rtl/rigid_body_twist_transform_core_assert.svh */
`ifndef RIGID_BODY_TWIST_TRANSFORM_CORE_ASSERT_SVH
`define RIGID_BODY_TWIST_TRANSFORM_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RBT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequence checked in the cycle after the antecedent
`define RBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/rbtt_pkg.sv */
package rbtt_pkg;
    localparam int VelFracBits = 16;
    localparam int NumRegs = 8;
    typedef enum logic [2:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_QUAT_W = 3'd3,
        REG_QUAT_X = 3'd4,
        REG_QUAT_Y = 3'd5,
        REG_QUAT_Z = 3'd6,
        REG_LOADED = 3'd7
    } reg_idx_t;
    typedef logic signed [31:0] vec3_t [3];
    typedef logic signed [33:0] mat_t [3][3];
    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic loaded;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] a);
        if (a > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (a < -66'sd2147483648)
            return 32'sh80000000;
        else
            return a[31:0];
    endfunction
endpackage

/* rtl/rigid_body_twist_transform_core.sv */
// Streaming twist transform: one request per cycle unless stalled; the shift
// and rotate stages feed the output register. All data stages advance
// together and stall only when the output register is full and not taken.
// Items with frame_ok low, or while no transform is loaded, give no output.
module rigid_body_twist_transform_core (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [191:0] s_axis_tdata, // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
    input  logic s_axis_tuser,         // frame_ok
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [191:0] m_axis_tdata, // out_lin_x..z, out_ang_x..z
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import rbtt_pkg::*;
`include "rigid_body_twist_transform_core_assert.svh"
    cfg_t cfg_reg;
    logic [3:0] vld_reg;
    logic en;
    vec3_t v_in, w_in, vs, w_d, ro_v, ro_w;
    mat_t m_reg;
    logic signed [31:0] qp_reg [10];
    logic signed [31:0] qs [10];

    assign cfg_ready = 1'b1;
    assign en = !vld_reg[3] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{rx: '0, ry: '0, rz: '0, qw: 16'sd16384, qx: '0, qy: '0,
                qz: '0, loaded: 1'b0};
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_OFFSET_X: cfg_reg.rx <= cfg_data;
                    REG_OFFSET_Y: cfg_reg.ry <= cfg_data;
                    REG_OFFSET_Z: cfg_reg.rz <= cfg_data;
                    REG_QUAT_W: cfg_reg.qw <= cfg_data[15:0];
                    REG_QUAT_X: cfg_reg.qx <= cfg_data[15:0];
                    REG_QUAT_Y: cfg_reg.qy <= cfg_data[15:0];
                    REG_QUAT_Z: cfg_reg.qz <= cfg_data[15:0];
                    REG_LOADED: cfg_reg.loaded <= cfg_data[0];
                    default: ;
                endcase
            end
            if (en)
                vld_reg <= {vld_reg[2:0],
                    s_axis_tvalid && s_axis_tuser && cfg_reg.loaded};
        end
    end

    // rotation matrix from quaternion, products then sums
    always_comb
    begin
        qs[0] = cfg_reg.qw * cfg_reg.qw;
        qs[1] = cfg_reg.qx * cfg_reg.qx;
        qs[2] = cfg_reg.qy * cfg_reg.qy;
        qs[3] = cfg_reg.qz * cfg_reg.qz;
        qs[4] = cfg_reg.qx * cfg_reg.qy;
        qs[5] = cfg_reg.qw * cfg_reg.qz;
        qs[6] = cfg_reg.qx * cfg_reg.qz;
        qs[7] = cfg_reg.qw * cfg_reg.qy;
        qs[8] = cfg_reg.qy * cfg_reg.qz;
        qs[9] = cfg_reg.qw * cfg_reg.qx;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 10; i++)
            qp_reg[i] <= qs[i];
        m_reg[0][0] <= 34'(qp_reg[0]) + 34'(qp_reg[1]) - 34'(qp_reg[2]) - 34'(qp_reg[3]);
        m_reg[1][1] <= 34'(qp_reg[0]) - 34'(qp_reg[1]) + 34'(qp_reg[2]) - 34'(qp_reg[3]);
        m_reg[2][2] <= 34'(qp_reg[0]) - 34'(qp_reg[1]) - 34'(qp_reg[2]) + 34'(qp_reg[3]);
        m_reg[0][1] <= (34'(qp_reg[4]) - 34'(qp_reg[5])) <<< 1;
        m_reg[0][2] <= (34'(qp_reg[6]) + 34'(qp_reg[7])) <<< 1;
        m_reg[1][0] <= (34'(qp_reg[4]) + 34'(qp_reg[5])) <<< 1;
        m_reg[1][2] <= (34'(qp_reg[8]) - 34'(qp_reg[9])) <<< 1;
        m_reg[2][0] <= (34'(qp_reg[6]) - 34'(qp_reg[7])) <<< 1;
        m_reg[2][1] <= (34'(qp_reg[8]) + 34'(qp_reg[9])) <<< 1;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_in[i] = s_axis_tdata[32 * i +: 32];
            w_in[i] = s_axis_tdata[96 + 32 * i +: 32];
        end
    end

    rbtt_shift u_shift (
        .clk(clk), .en(en), .v(v_in), .w(w_in), .cfg(cfg_reg), .vs(vs), .w_d(w_d)
    );
    rbtt_rotate u_rot_v (.clk(clk), .en(en), .m(m_reg), .u(vs), .ro(ro_v));
    rbtt_rotate u_rot_w (.clk(clk), .en(en), .m(m_reg), .u(w_d), .ro(ro_w));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_axis_tdata[32 * i +: 32] = ro_v[i];
            m_axis_tdata[96 + 32 * i +: 32] = ro_w[i];
        end
    end

    `RBT_ASSERT_IMPL(a_stall_holds, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `RBT_ASSERT_NEXT(a_drop_frame, s_axis_tvalid && s_axis_tready && !s_axis_tuser,
        !vld_reg[0])
    `RBT_ASSERT_NEXT(a_out_keeps, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

/* rtl/rbtt_shift.sv */
module rbtt_shift (
    input  logic clk,
    input  logic en,
    input  rbtt_pkg::vec3_t v,
    input  rbtt_pkg::vec3_t w,
    input  rbtt_pkg::cfg_t cfg,
    output rbtt_pkg::vec3_t vs,
    output rbtt_pkg::vec3_t w_d
);
    import rbtt_pkg::*;
    logic signed [63:0] p1_reg [3];
    logic signed [63:0] p2_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] vs_reg [3];
    logic signed [31:0] w2_reg [3];
    logic signed [31:0] r [3];
    logic signed [65:0] c [3];
    assign r[0] = cfg.rx;
    assign r[1] = cfg.ry;
    assign r[2] = cfg.rz;

    // products registered, then difference, round and add
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= w[(i + 1) % 3] * r[(i + 2) % 3];
                p2_reg[i] <= w[(i + 2) % 3] * r[(i + 1) % 3];
                v_reg[i] <= v[i];
                w_reg[i] <= w[i];
                vs_reg[i] <= sat32(66'(v_reg[i]) + c[i]);
                w2_reg[i] <= w_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c[i] = (66'(p1_reg[i]) - 66'(p2_reg[i])
                + (66'sd1 <<< (VelFracBits - 1))) >>> VelFracBits;
    end

    assign vs = vs_reg;
    assign w_d = w2_reg;
endmodule

/* rtl/rbtt_rotate.sv */
module rbtt_rotate (
    input  logic clk,
    input  logic en,
    input  rbtt_pkg::mat_t m,
    input  rbtt_pkg::vec3_t u,
    output rbtt_pkg::vec3_t ro
);
    import rbtt_pkg::*;
    logic signed [65:0] prod_reg [3][3];
    logic signed [31:0] ro_reg [3];
    logic signed [67:0] acc [3];

    // exact dot product then round at 28 fraction bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= m[i][j] * u[j];
                ro_reg[i] <= sat32(66'(acc[i] >>> 28));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            acc[i] = 68'(prod_reg[i][0]) + 68'(prod_reg[i][1]) + 68'(prod_reg[i][2])
                + 68'sd134217728;
    end

    assign ro = ro_reg;
endmodule
